// File: rtl/ble_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ble_pkg;

  // Largest number of entries the list can hold.
  localparam int CAPACITY = 32;

  // Width of a cell address and of the entry counter.
  localparam int CAP_AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W  = $clog2(CAPACITY + 1);

  // Fixed field widths of the transfer payloads.
  localparam int KIND_W    = 3;
  localparam int VALUE_W   = 32;
  localparam int POS_W     = 6;
  localparam int STATUS_W  = 2;
  localparam int ENTRIES_W = 7;

  typedef enum logic [KIND_W-1:0] {
    KIND_INS_FRONT = 3'd0,
    KIND_INS_BACK  = 3'd1,
    KIND_DEL_FRONT = 3'd2,
    KIND_DEL_BACK  = 3'd3,
    KIND_DEL_AT    = 3'd4,
    KIND_COUNT     = 3'd5,
    KIND_READ_ALL  = 3'd6
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK     = 2'd0,
    STATUS_EMPTY  = 2'd1,
    STATUS_BADPOS = 2'd2,
    STATUS_FULL   = 2'd3
  } status_e;

  typedef struct packed {
    kind_e                     kind;
    logic signed [VALUE_W-1:0] value;
    logic [POS_W-1:0]          position;
  } in_item_t;

  typedef struct packed {
    status_e                   status;
    logic signed [VALUE_W-1:0] element;
    logic [ENTRIES_W-1:0]      entries;
    logic                      last;
  } out_item_t;

endpackage

`default_nettype wire

// File: rtl/bounded_list_engine.sv
// Insert front/back, delete front/back, count and unused codes: accepted in ST_IDLE, result
// loaded into the output register from ST_RESP once the output register is free.
// Delete at position P: every entry behind P moves one cell forward, by a read and a write per moved cell.
// Read all: entries come out one at a time, since the cell memory has a single read port.
// One item is worked on at a time; the next is accepted once the last result is loaded.
// Reset clears the entry count and the front pointer; the cell memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module bounded_list_engine (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire ble_pkg::in_item_t  in_item_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output ble_pkg::out_item_t      out_item_o
);

  import ble_pkg::*;

  // The list lives in a circular buffer: head_q is the cell that holds the
  // front entry, and entry i sits at (head_q + i) wrapped at the capacity.
  // Inserts and deletes at either end only move the head or the count.
  // A delete in the middle pulls every later entry one place toward the
  // front, one cell per read and write pair through the memory.

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RESP,
    ST_SH_REQ,
    ST_SH_WR,
    ST_RD_REQ,
    ST_RD_WAIT
  } state_e;

  localparam logic [CAP_AW:0] CAP_EXT = (CAP_AW + 1)'(CAPACITY);
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  state_e             state_q, state_d;
  logic [CAP_AW-1:0]  head_q, head_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [CAP_AW-1:0]  idx_q, idx_d;
  status_e            status_q, status_d;
  logic               out_valid_q, out_valid_d;
  out_item_t          out_q, out_d;

  // Shared address unit: head plus an offset, wrapped once at the capacity.
  logic [CAP_AW-1:0]  offset;
  logic [CAP_AW:0]    addr_sum;
  logic [CAP_AW-1:0]  phys;

  // Cell memory ports.
  logic               ram_we;
  logic [CAP_AW-1:0]  ram_waddr;
  logic [VALUE_W-1:0] ram_wdata;
  logic               ram_re;
  logic [VALUE_W-1:0] ram_rdata;

  logic               in_xfer;
  logic               out_free;
  logic               full;
  logic               empty;
  logic [CAP_AW-1:0]  idx_inc;
  logic [CNT_W-1:0]   idx_next_cnt;
  logic [ENTRIES_W-1:0] pos_ext;
  logic [ENTRIES_W-1:0] count_ext;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  assign full         = (count_q == CAP_CNT);
  assign empty        = (count_q == '0);
  assign idx_inc      = idx_q + CAP_AW'(1);
  assign idx_next_cnt = CNT_W'(idx_q) + CNT_W'(1);
  assign pos_ext      = ENTRIES_W'(in_item_i.position);
  assign count_ext    = ENTRIES_W'(count_q);

  // Offset selection for the shared address unit.
  always_comb begin
    offset = idx_q;
    case (state_q)
      ST_IDLE: begin
        case (in_item_i.kind)
          KIND_INS_FRONT: offset = CAP_AW'(CAPACITY - 1);
          KIND_INS_BACK:  offset = count_q[CAP_AW-1:0];
          KIND_DEL_FRONT: offset = CAP_AW'(1);
          default:        offset = idx_q;
        endcase
      end
      ST_SH_REQ: offset = idx_inc;
      default:   offset = idx_q;
    endcase
  end

  assign addr_sum = {1'b0, head_q} + {1'b0, offset};
  assign phys     = (addr_sum >= CAP_EXT) ? CAP_AW'(addr_sum - CAP_EXT) : addr_sum[CAP_AW-1:0];

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    count_d     = count_q;
    idx_d       = idx_q;
    status_d    = status_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    ram_we      = 1'b0;
    ram_waddr   = phys;
    ram_wdata   = in_item_i.value;
    ram_re      = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          status_d = STATUS_OK;
          state_d  = ST_RESP;
          case (in_item_i.kind)
            KIND_INS_FRONT: begin
              if (full) begin
                status_d = STATUS_FULL;
              end else begin
                ram_we  = 1'b1;
                head_d  = phys;
                count_d = count_q + CNT_W'(1);
              end
            end
            KIND_INS_BACK: begin
              if (full) begin
                status_d = STATUS_FULL;
              end else begin
                ram_we  = 1'b1;
                count_d = count_q + CNT_W'(1);
              end
            end
            KIND_DEL_FRONT: begin
              if (empty) begin
                status_d = STATUS_EMPTY;
              end else begin
                head_d  = phys;
                count_d = count_q - CNT_W'(1);
              end
            end
            KIND_DEL_BACK: begin
              if (empty) begin
                status_d = STATUS_EMPTY;
              end else begin
                count_d = count_q - CNT_W'(1);
              end
            end
            KIND_DEL_AT: begin
              if (empty) begin
                status_d = STATUS_EMPTY;
              end else if (pos_ext >= count_ext) begin
                status_d = STATUS_BADPOS;
              end else begin
                idx_d   = in_item_i.position[CAP_AW-1:0];
                state_d = ST_SH_REQ;
              end
            end
            KIND_READ_ALL: begin
              if (empty) begin
                status_d = STATUS_EMPTY;
              end else begin
                idx_d   = '0;
                state_d = ST_RD_REQ;
              end
            end
            default: begin
              status_d = STATUS_OK;
            end
          endcase
        end
      end

      ST_SH_REQ: begin
        // Fetch the entry behind idx_q, or finish once idx_q is the tail.
        if (idx_next_cnt < count_q) begin
          ram_re  = 1'b1;
          state_d = ST_SH_WR;
        end else begin
          count_d = count_q - CNT_W'(1);
          state_d = ST_RESP;
        end
      end

      ST_SH_WR: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
        idx_d     = idx_inc;
        state_d   = ST_SH_REQ;
      end

      ST_RD_REQ: begin
        ram_re  = 1'b1;
        state_d = ST_RD_WAIT;
      end

      ST_RD_WAIT: begin
        // The read data holds until the output register can take it.
        if (out_free) begin
          out_valid_d   = 1'b1;
          out_d.status  = STATUS_OK;
          out_d.element = ram_rdata;
          out_d.entries = count_ext;
          out_d.last    = (idx_next_cnt == count_q);
          if (idx_next_cnt == count_q) begin
            state_d = ST_IDLE;
          end else begin
            idx_d   = idx_inc;
            state_d = ST_RD_REQ;
          end
        end
      end

      ST_RESP: begin
        if (out_free) begin
          out_valid_d   = 1'b1;
          out_d.status  = status_q;
          out_d.element = '0;
          out_d.entries = count_ext;
          out_d.last    = 1'b1;
          state_d       = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      idx_q       <= '0;
      status_q    <= STATUS_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      status_q    <= status_d;
      out_valid_q <= out_valid_d;
    end
  end

  // The result payload needs no reset; it is only looked at while valid.
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  ble_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (CAPACITY)
  ) u_cells (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (phys),
    .rdata_o (ram_rdata)
  );

  // The count never grows past the capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CAP_CNT)
    else $error("entry count exceeds capacity");

  // With no transfer in the idle state, the list shape does not change.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) && !in_valid_i |=> $stable(count_q) && $stable(head_q))
    else $error("list changed without an accepted item");

  // A read of a non-empty list starts walking the cells.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && (in_item_i.kind == KIND_READ_ALL) && !empty |=> (state_q == ST_RD_REQ))
    else $error("read all did not start the cell walk");

  // An item that shifts cells finishes with one fewer entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SH_REQ) && (idx_next_cnt >= count_q)
      |=> (count_q == $past(count_q) - CNT_W'(1)))
    else $error("delete at position lost count");

endmodule

`default_nettype wire

// File: rtl/ble_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module ble_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                         wdata_i,
  input  wire logic                                     re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: sim/bounded_list_engine_tb.sv
`timescale 1ns / 1ps

module bounded_list_engine_tb;
  import ble_pkg::*;

  // Clocking and run shape.
  localparam int HALF_PERIOD     = 2;
  localparam int RESET_CYCLES    = 8;
  localparam int RANDOM_ITEMS    = 500;
  // The receiver stalls once for a long hold-off, well into the run.
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int HOLD_OFF_AT     = 250;
  // A delete at position zero of a full list, which moves every later cell, is among
  // the longest single operations, so this covers any trailing work.
  localparam int SETTLE_CYCLES   = 200;

  // The one kind code that the package enum leaves unnamed.
  localparam logic [KIND_W-1:0] KIND_UNUSED = 3'd7;

  typedef logic signed [VALUE_W-1:0] value_t;

  // One queued request, plus a flag that makes the driver wait until the
  // engine has returned every outstanding result before offering it.
  typedef struct {
    in_item_t item;
    bit       drain_first;
  } request_t;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  bounded_list_engine dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  always #HALF_PERIOD clk = ~clk;

  // Requests waiting to be offered, filled once before reset is released.
  request_t    request_queue [$];
  int unsigned total_requests;
  int unsigned requests_offered  = 0;
  int unsigned requests_accepted = 0;
  int unsigned mismatches        = 0;

  // Our own copy of the list, updated as each request is accepted, and the
  // results that the engine still owes us, oldest first.
  value_t      list_copy [CAPACITY];
  int unsigned list_length = 0;
  out_item_t   owed_results [$];

  // Receiver hold-off bookkeeping, owned by the receiver process.
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;

  // ---------------------------------------------------------------------------
  // List predictor
  // ---------------------------------------------------------------------------

  function automatic void owe_result(status_e st, value_t elem, bit fin);
    out_item_t r;
    r.status  = st;
    r.element = elem;
    r.entries = ENTRIES_W'(list_length);
    r.last    = fin;
    owed_results.push_back(r);
  endfunction

  // Close the gap at a position by shifting the later cells one step forward.
  function automatic void remove_cell(int unsigned pos);
    int unsigned i;
    for (i = pos; i + 1 < list_length; i++) list_copy[i] = list_copy[i + 1];
    list_length--;
  endfunction

  // Apply one accepted request to the list copy and queue up every result
  // that the engine should return for it.
  function automatic void apply_request(in_item_t it);
    int unsigned i;
    status_e     st;
    st = STATUS_OK;
    case (it.kind)
      KIND_INS_FRONT: begin
        if (list_length >= CAPACITY) begin
          st = STATUS_FULL;
        end else begin
          for (i = list_length; i > 0; i--) list_copy[i] = list_copy[i - 1];
          list_copy[0] = it.value;
          list_length++;
        end
      end
      KIND_INS_BACK: begin
        if (list_length >= CAPACITY) begin
          st = STATUS_FULL;
        end else begin
          list_copy[list_length] = it.value;
          list_length++;
        end
      end
      KIND_DEL_FRONT: begin
        if (list_length == 0) st = STATUS_EMPTY;
        else remove_cell(0);
      end
      KIND_DEL_BACK: begin
        if (list_length == 0) st = STATUS_EMPTY;
        else list_length--;
      end
      KIND_DEL_AT: begin
        if (list_length == 0) st = STATUS_EMPTY;
        else if (it.position >= list_length) st = STATUS_BADPOS;
        else remove_cell(it.position);
      end
      KIND_READ_ALL: begin
        // A read-out of an empty list still yields one result, flagged empty.
        if (list_length == 0) begin
          owe_result(STATUS_EMPTY, '0, 1'b1);
        end else begin
          for (i = 0; i < list_length; i++) begin
            owe_result(STATUS_OK, list_copy[i], i + 1 == list_length);
          end
        end
        return;
      end
      default: ;  // Count, and the unused code, change nothing.
    endcase
    owe_result(st, '0, 1'b1);
  endfunction

  // ---------------------------------------------------------------------------
  // Idling profile: three phases, each a third of the requests. The sender
  // idles 32 % then 74 % then never; the receiver idles 74 % then 32 % then never.
  // ---------------------------------------------------------------------------

  function automatic int unsigned sender_idle_pct();
    case (requests_offered * 3 / total_requests)
      0:       return 32;
      1:       return 74;
      default: return 0;
    endcase
  endfunction

  function automatic int unsigned receiver_idle_pct();
    case (requests_accepted * 3 / total_requests)
      0:       return 74;
      1:       return 32;
      default: return 0;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: works on the falling edge. An offered request stays on the bus
  // until the checker has seen it accepted; only then may the driver move on
  // to the next request or idle. Valid is never steered by the stall.
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin
    if (rst_n && !(in_valid && requests_accepted != requests_offered)) begin
      if (request_queue.size() > 0 &&
          (!request_queue[0].drain_first || owed_results.size() == 0) &&
          $urandom_range(0, 99) >= sender_idle_pct()) begin
        in_item  <= request_queue[0].item;
        in_valid <= 1'b1;
        void'(request_queue.pop_front());
        requests_offered++;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stall, except for one long hold-off in the middle of
  // the run so that the engine backs up and stalls its own input.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (!hold_done && requests_accepted >= HOLD_OFF_AT) begin
      out_stall <= 1'b1;
      hold_done = 1'b1;
      hold_left = HOLD_OFF_CYCLES - 1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < receiver_idle_pct());
    end
  end

  // ---------------------------------------------------------------------------
  // Checker: on the rising edge, first match any result transfer against the
  // oldest owed result, then account for a request transfer. Doing both in
  // one process keeps the queue updates in a fixed order.
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (owed_results.size() == 0) begin
        $display("%0t: unexpected result status=%0d element=%0d entries=%0d last=%0d",
                 $time, out_item.status, out_item.element, out_item.entries, out_item.last);
        mismatches++;
      end else begin
        out_item_t want;
        want = owed_results.pop_front();
        if (out_item.status !== want.status || out_item.element !== want.element ||
            out_item.entries !== want.entries || out_item.last !== want.last) begin
          $display("%0t: mismatch: expected status=%0d element=%0d entries=%0d last=%0d",
                   $time, want.status, want.element, want.entries, want.last);
          $display("%0t:           actual   status=%0d element=%0d entries=%0d last=%0d",
                   $time, out_item.status, out_item.element, out_item.entries,
                   out_item.last);
          mismatches++;
        end
      end
    end
    if (rst_n && in_valid && !in_stall) begin
      apply_request(in_item);
      requests_accepted++;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  function automatic void queue_request(logic [KIND_W-1:0] k, value_t v,
                                        logic [POS_W-1:0] p, bit drain);
    request_t r;
    r.item.kind     = kind_e'(k);
    r.item.value    = v;
    r.item.position = p;
    r.drain_first   = drain;
    request_queue.push_back(r);
  endfunction

  function automatic value_t any_value();
    case ($urandom_range(0, 9))
      0:       return {1'b0, {(VALUE_W - 1){1'b1}}};
      1:       return {1'b1, {(VALUE_W - 1){1'b0}}};
      default: return value_t'($urandom());
    endcase
  endfunction

  // Mostly positions that can land inside the list, sometimes any position.
  function automatic logic [POS_W-1:0] any_position();
    if ($urandom_range(0, 3) == 0) return POS_W'($urandom_range(0, 63));
    return POS_W'($urandom_range(0, CAPACITY - 1));
  endfunction

  task automatic build_directed();
    // Every non-insert operation on an empty list, including the unused code.
    queue_request(KIND_READ_ALL, '0, '0, 1'b0);
    queue_request(KIND_COUNT, '0, '0, 1'b0);
    queue_request(KIND_DEL_FRONT, '0, '0, 1'b0);
    queue_request(KIND_DEL_BACK, '0, '0, 1'b0);
    queue_request(KIND_DEL_AT, '0, '0, 1'b0);
    queue_request(KIND_UNUSED, '1, '1, 1'b0);
    // Extreme values at both ends of the list.
    queue_request(KIND_INS_FRONT, 32'sh7FFF_FFFF, '1, 1'b0);
    queue_request(KIND_INS_BACK, 32'sh8000_0000, '0, 1'b0);
    queue_request(KIND_INS_FRONT, -32'sd1, '0, 1'b0);
    queue_request(KIND_INS_BACK, '0, '0, 1'b0);
    queue_request(KIND_INS_BACK, 32'sh1234_5678, '0, 1'b0);
    queue_request(KIND_COUNT, '0, '0, 1'b0);
    queue_request(KIND_READ_ALL, '0, '0, 1'b0);
    // Positions past the end: the top position and exactly the count.
    queue_request(KIND_DEL_AT, '0, 6'd63, 1'b0);
    queue_request(KIND_DEL_AT, '0, 6'd5, 1'b0);
    // Middle, last and first positions.
    queue_request(KIND_DEL_AT, '0, 6'd2, 1'b0);
    queue_request(KIND_DEL_AT, '0, 6'd3, 1'b0);
    queue_request(KIND_DEL_AT, '0, 6'd0, 1'b0);
    queue_request(KIND_UNUSED, '0, '0, 1'b0);
    queue_request(KIND_READ_ALL, '0, '0, 1'b0);
    queue_request(KIND_DEL_FRONT, '0, '0, 1'b0);
    queue_request(KIND_DEL_BACK, '0, '0, 1'b0);
    queue_request(KIND_COUNT, '0, '0, 1'b0);
  endtask

  // The random part runs in segments. A fill segment always overruns the
  // capacity, so full-list inserts and full read-outs recur; a drain segment
  // mostly empties the list again; a mixed segment throws every code at it.
  task automatic build_random();
    int unsigned made;
    int unsigned seg_no;
    int unsigned n;
    int unsigned j;
    int unsigned flavor;
    bit          drain;
    made   = 0;
    seg_no = 0;
    while (made < RANDOM_ITEMS) begin
      flavor = (seg_no == 0) ? 0 : $urandom_range(0, 2);
      // Every so often the sender waits for the engine to go quiet first.
      drain  = (seg_no % 6 == 3);
      case (flavor)
        0: begin
          n = $urandom_range(CAPACITY + 2, CAPACITY + 8);
          for (j = 0; j < n; j++) begin
            queue_request($urandom_range(0, 1) ? KIND_INS_FRONT : KIND_INS_BACK,
                          any_value(), any_position(), drain && j == 0);
          end
        end
        1: begin
          n = $urandom_range(20, 40);
          for (j = 0; j < n; j++) begin
            case ($urandom_range(0, 3))
              0:       queue_request(KIND_DEL_FRONT, any_value(), any_position(),
                                     drain && j == 0);
              1:       queue_request(KIND_DEL_BACK, any_value(), any_position(),
                                     drain && j == 0);
              default: queue_request(KIND_DEL_AT, any_value(), any_position(),
                                     drain && j == 0);
            endcase
          end
        end
        default: begin
          n = $urandom_range(10, 30);
          for (j = 0; j < n; j++) begin
            queue_request(KIND_W'($urandom_range(0, 7)), any_value(), any_position(),
                          drain && j == 0);
          end
        end
      endcase
      made += n;
      // Read the list back after about half the segments.
      if ($urandom_range(0, 1)) begin
        queue_request(KIND_READ_ALL, any_value(), any_position(), 1'b0);
        made++;
      end
      seg_no++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Run control
  // ---------------------------------------------------------------------------

  initial begin
    build_directed();
    build_random();
    total_requests = request_queue.size();

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Every request must be taken, then every owed result returned.
    while (requests_accepted < total_requests) @(negedge clk);
    while (owed_results.size() > 0) @(negedge clk);
    // Stay a while longer so that any stray extra result is caught.
    repeat (SETTLE_CYCLES) @(negedge clk);

    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run at these idling rates.
  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
